// ===== src/bcw_pkg.sv =====
// Shared types and constants for the 3x3 binary inner-boundary window.
// No dependencies; every other file in src except bcw_ram uses this package.
package bcw_pkg;

    // Fixed field and counter widths
    localparam int PIXEL_W  = 8;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int COUNT_W  = 26;
    localparam int TOTAL_W  = 27;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    // Defaults
    localparam int DEF_MAX_WIDTH = 1024;
    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(480);
    localparam logic [TOTAL_W-1:0]  RESET_TOTAL  = TOTAL_W'(640 * 480);

    // Pixel codes
    localparam logic [PIXEL_W-1:0] PIX_WHITE   = 8'd255;
    localparam logic [PIXEL_W-1:0] PIX_CONTOUR = 8'd127;
    localparam logic [PIXEL_W-1:0] PIX_BLACK   = 8'd0;

    // Input beat kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // Register map, selected by paddr[2]
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    // One result beat
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_end;
    } out_beat_t;

    // Remainder unit status toward the top level
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [WIDTH_W-1:0] rem;
    } rem_status_t;

endpackage

// ===== src/bcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on an address collision. Depends on nothing.
module bcw_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bcw_rem_unit.sv =====
// Restoring remainder unit, one dividend bit per cycle.
// Realigns the output column counter after a width change. Uses bcw_pkg.
module bcw_rem_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bcw_pkg::COUNT_W-1:0] dividend,
    input  logic [bcw_pkg::WIDTH_W-1:0] divisor,
    output bcw_pkg::rem_status_t        status
);
    import bcw_pkg::*;

    localparam int CNT_W = $clog2(COUNT_W);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WIDTH_W:0]     rem_reg, rem_next;
    logic [COUNT_W-1:0]   dvd_reg, dvd_next;
    logic [WIDTH_W-1:0]   dsr_reg, dsr_next;
    logic [WIDTH_W:0]     shifted;
    logic [WIDTH_W:0]     rem_step;
    logic                 last_step;

    // One restoring step
    always_comb begin
        shifted   = {rem_reg[WIDTH_W-1:0], dvd_reg[COUNT_W-1]};
        rem_step  = (shifted >= {1'b0, dsr_reg}) ? shifted - {1'b0, dsr_reg} : shifted;
        last_step = busy_reg && (cnt_reg == '0);
    end

    // Sequencing
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(COUNT_W - 1);
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = rem_step;
            dvd_next = {dvd_reg[COUNT_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = last_step;
    assign status.rem  = rem_step[WIDTH_W-1:0];

endmodule

// ===== src/bcw_out_buf.sv =====
// Two-beat result buffer between the window logic and the output channel.
// Lets the input side keep going while a result waits. Uses bcw_pkg.
module bcw_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  bcw_pkg::out_beat_t push_beat,
    output logic               pop_valid,
    input  logic               pop_ready,
    output bcw_pkg::out_beat_t pop_beat,
    output logic               has_room
);
    import bcw_pkg::*;

    out_beat_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (cnt_reg != 2'd0);
    assign pop_beat  = entry_reg[rd_ptr_reg];
    assign has_room  = (cnt_reg != 2'd2);

    // Occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (push_valid && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push_valid && pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Pointers and storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push_valid) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

// ===== src/binary_contour_window_3x3_unit.sv =====
// Streaming 3x3 inner-boundary marker: top level with register port.
// A result beat is registered in the result buffer before it shows on m_*;
// results trail input positions by width+1 items. Throughput: one item per
// cycle while the result buffer has room, set by the line-store read port; after a
// width write the input stalls while the remainder unit realigns the output column counter.
// Reset: synchronous, active low; counters, window and buffer clear, line stores keep content.
module binary_contour_window_3x3_unit #(
    parameter int MAX_WIDTH = bcw_pkg::DEF_MAX_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcw_pkg::ADDR_W-1:0]  paddr,
    input  logic [bcw_pkg::DATA_W-1:0]  pwdata,
    output logic [bcw_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [bcw_pkg::PIXEL_W-1:0] s_pixel,
    // Result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bcw_pkg::PIXEL_W-1:0] m_out_pixel,
    output logic                        m_frame_end
);
    import bcw_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;

    // Registers
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [COUNT_W-1:0]  emitted_reg, emitted_next;
    logic [WIDTH_W-1:0]  ccol_reg, ccol_next;
    logic [PIXEL_W-1:0]  win_reg [9];
    logic [PIXEL_W-1:0]  win_next [9];
    logic                byp_reg;
    logic [PIXEL_W-1:0]  byp_top_reg, byp_mid_reg;

    // Config decode
    logic               cfg_wr;
    logic [WIDTH_W-1:0] w_in;
    logic [HEIGHT_W-1:0] h_in;
    logic               w_ok, h_ok;
    reg_index_t         cfg_sel;

    // Datapath
    logic                accept, push, emit, input_done, pos_low, last, border, any_zero;
    logic [PIXEL_W-1:0]  pix_in, top_pix, mid_pix, ram_top, ram_mid, center;
    logic [COL_W-1:0]    col_adv;
    logic [HEIGHT_W-1:0] row_adv;
    logic [WIDTH_W-1:0]  ccol_adv;
    out_beat_t           beat;
    logic                buf_room;
    rem_status_t         rem_st;
    out_beat_t           pop_beat;

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = reg_index_t'(paddr[2]);
    assign w_in    = pwdata[WIDTH_W-1:0];
    assign h_in    = pwdata[HEIGHT_W-1:0];
    assign w_ok    = (w_in != '0) && (32'(w_in) <= 32'(MAX_WIDTH));
    assign h_ok    = (h_in != '0);

    always_comb begin
        unique case (cfg_sel)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Register updates and frame size product
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        total_next  = total_reg;
        if (cfg_wr) begin
            unique case (cfg_sel)
                REG_WIDTH: begin
                    if (w_ok) begin
                        width_next = w_in;
                        total_next = TOTAL_W'(w_in * height_reg);
                    end
                end
                REG_HEIGHT: begin
                    if (h_ok) begin
                        height_next = h_in;
                        total_next  = TOTAL_W'(width_reg * h_in);
                    end
                end
                default: ;
            endcase
        end
    end

    // Input handshake and item classification
    assign s_ready    = buf_room && !rem_st.busy;
    assign accept     = s_valid && s_ready;
    assign input_done = (row_reg >= height_reg);
    assign push       = accept && (input_done || (s_mode == MODE_PIXEL));
    assign pix_in     = input_done ? PIX_BLACK : s_pixel;
    assign pos_low    = ((row_reg == '0) && (CMP_W'(col_reg) <= CMP_W'(width_reg)))
                     || ((row_reg == HEIGHT_W'(1)) && (col_reg == '0));
    assign emit       = push && !pos_low;

    // Line store outputs, forwarded when the next column is the one just written
    assign top_pix = byp_reg ? byp_top_reg : ram_top;
    assign mid_pix = byp_reg ? byp_mid_reg : ram_mid;

    // Shift the window by one column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r*3 + 0] = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = top_pix;
        win_next[5] = mid_pix;
        win_next[8] = pix_in;
    end

    // Judge the center pixel
    always_comb begin
        center   = win_next[4];
        any_zero = 1'b0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4 && win_next[k] == PIX_BLACK) begin
                any_zero = 1'b1;
            end
        end
        border = (TOTAL_W'(emitted_reg) < TOTAL_W'(width_reg))
              || ((TOTAL_W'(emitted_reg) + TOTAL_W'(width_reg)) >= total_reg)
              || (ccol_reg == '0)
              || ((12'(ccol_reg) + 12'd1) >= 12'(width_reg));
        last = (TOTAL_W'(emitted_reg) + TOTAL_W'(1)) >= total_reg;
        beat.pixel     = (!border && center == PIX_WHITE && any_zero) ? PIX_CONTOUR : center;
        beat.frame_end = last;
    end

    // Advance input and output positions
    always_comb begin
        if ((CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(width_reg)) begin
            col_adv = '0;
            row_adv = (row_reg == '1) ? row_reg : row_reg + 1'b1;
        end else begin
            col_adv = col_reg + 1'b1;
            row_adv = row_reg;
        end
        ccol_adv = ((12'(ccol_reg) + 12'd1) >= 12'(width_reg)) ? '0 : ccol_reg + 1'b1;

        col_next     = col_reg;
        row_next     = row_reg;
        emitted_next = emitted_reg;
        ccol_next    = ccol_reg;
        if (push) begin
            col_next = col_adv;
            row_next = row_adv;
        end
        if (emit) begin
            if (last) begin
                col_next     = '0;
                row_next     = '0;
                emitted_next = '0;
                ccol_next    = '0;
            end else begin
                emitted_next = emitted_reg + 1'b1;
                ccol_next    = ccol_adv;
            end
        end
        if (rem_st.done) begin
            ccol_next = rem_st.rem;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RESET_WIDTH;
            height_reg  <= RESET_HEIGHT;
            total_reg   <= RESET_TOTAL;
            col_reg     <= '0;
            row_reg     <= '0;
            emitted_reg <= '0;
            ccol_reg    <= '0;
            byp_reg     <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= PIX_BLACK;
            end
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            total_reg   <= total_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            emitted_reg <= emitted_next;
            ccol_reg    <= ccol_next;
            if (push) begin
                byp_reg <= (col_next == col_reg);
                for (int k = 0; k < 9; k++) begin
                    win_reg[k] <= win_next[k];
                end
            end
        end
        if (push) begin
            byp_top_reg <= mid_pix;
            byp_mid_reg <= pix_in;
        end
    end

    // Line stores: write the current column, prefetch the next one
    bcw_ram #(
        .DATA_W (PIXEL_W),
        .DEPTH  (MAX_WIDTH)
    ) u_upper_store (
        .aclk  (aclk),
        .we    (push),
        .waddr (col_reg),
        .wdata (mid_pix),
        .re    (push),
        .raddr (col_next),
        .rdata (ram_top)
    );

    bcw_ram #(
        .DATA_W (PIXEL_W),
        .DEPTH  (MAX_WIDTH)
    ) u_middle_store (
        .aclk  (aclk),
        .we    (push),
        .waddr (col_reg),
        .wdata (pix_in),
        .re    (push),
        .raddr (col_next),
        .rdata (ram_mid)
    );

    // Column realignment after a width change
    bcw_rem_unit u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cfg_wr && (cfg_sel == REG_WIDTH) && w_ok),
        .dividend (emitted_reg),
        .divisor  (w_in),
        .status   (rem_st)
    );

    // Result buffer
    bcw_out_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (emit),
        .push_beat  (beat),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_beat   (pop_beat),
        .has_room   (buf_room)
    );

    assign m_out_pixel = pop_beat.pixel;
    assign m_frame_end = pop_beat.frame_end;

endmodule

// ===== src/bcw_checker.sv =====
// Port-level checks for the inner-boundary window, bound to the top level.
// Uses bcw_pkg; sees only the top level's ports.
module bcw_checker #(
    parameter int MAX_WIDTH = bcw_pkg::DEF_MAX_WIDTH
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [bcw_pkg::ADDR_W-1:0]  paddr,
    input logic [bcw_pkg::DATA_W-1:0]  pwdata,
    input logic [bcw_pkg::DATA_W-1:0]  prdata,
    input logic                        pready,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_mode,
    input logic [bcw_pkg::PIXEL_W-1:0] s_pixel,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [bcw_pkg::PIXEL_W-1:0] m_out_pixel,
    input logic                        m_frame_end
);
    import bcw_pkg::*;

    logic wr_beat, width_ok, height_ok;

    assign wr_beat   = psel && penable && pwrite && pready;
    assign width_ok  = (pwdata[WIDTH_W-1:0] != '0)
                    && (32'(pwdata[WIDTH_W-1:0]) <= 32'(MAX_WIDTH));
    assign height_ok = (pwdata[HEIGHT_W-1:0] != '0);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_pixel) && $stable(m_frame_end))
        else $error("result beat changed while stalled");

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // Accepted width change stalls the input while the column is realigned
    a_width_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_beat && !paddr[2] && width_ok |=> !s_ready)
        else $error("input not stalled after width change");

    // Height readback shows the value just written
    a_height_rb: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_beat && paddr[2] && height_ok |=>
            (!paddr[2] || (prdata == DATA_W'($past(pwdata[HEIGHT_W-1:0])))))
        else $error("height readback mismatch");

endmodule

bind binary_contour_window_3x3_unit bcw_checker #(.MAX_WIDTH(MAX_WIDTH)) u_bcw_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_mode      (s_mode),
    .s_pixel     (s_pixel),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_pixel (m_out_pixel),
    .m_frame_end (m_frame_end)
);

// ===== tb/binary_contour_window_3x3_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the streaming 3x3 inner-boundary marker: a directed table, then
// random frames over several geometries. Depends on bcw_pkg and the top level in src.
module binary_contour_window_3x3_unit_test;
    import bcw_pkg::*;

    localparam int LINE_DEPTH    = DEF_MAX_WIDTH;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BEATS  = 1200;
    localparam int REPORT_CAP    = 40;

    typedef enum logic [1:0] {ROW_WRITE, ROW_READ, ROW_BEAT} row_kind_e;
    typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_TYPED} check_e;
    typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_HALF, SINK_CHOKED} sink_style_e;

    // One directed step: register write/read, or an input beat with its check
    typedef struct packed {
        row_kind_e          kind;
        reg_index_t         idx;
        logic [DATA_W-1:0]  data;
        logic               mode;
        logic [PIXEL_W-1:0] pix;
        check_e             chk;
        logic [PIXEL_W-1:0] exp_pix;
        logic               exp_end;
    } step_row_t;

    localparam int SCRIPT_LEN = 39;
    localparam step_row_t SCRIPT [SCRIPT_LEN] = '{
        // reset values, rejected writes, extremes, masking of upper data bits
        '{ROW_READ,  REG_WIDTH,  32'd640,       MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_READ,  REG_HEIGHT, 32'd480,       MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, REG_WIDTH,  32'd0,         MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, REG_WIDTH,  32'd1025,      MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_READ,  REG_WIDTH,  32'd640,       MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, REG_HEIGHT, 32'h0001_0000, MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_READ,  REG_HEIGHT, 32'd480,       MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, REG_WIDTH,  32'd1024,      MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_READ,  REG_WIDTH,  32'd1024,      MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, REG_HEIGHT, 32'd65535,     MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_READ,  REG_HEIGHT, 32'd65535,     MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, REG_WIDTH,  32'hFFFF_F801, MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_READ,  REG_WIDTH,  32'd1,         MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, REG_HEIGHT, 32'd1,         MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_READ,  REG_HEIGHT, 32'd1,         MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        // 1x1 frames: early drain, lag of two, surplus pixel acting as drain
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_DRAIN, 8'hFF, CHK_QUIET, 8'h00,       1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, 8'hA5, CHK_QUIET, 8'h00,       1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_DRAIN, 8'h00, CHK_QUIET, 8'h00,       1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, 8'h3C, CHK_TYPED, 8'hA5,       1'b1},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, 8'h00, CHK_QUIET, 8'h00,       1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_DRAIN, 8'h5A, CHK_QUIET, 8'h00,       1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_DRAIN, 8'hC3, CHK_TYPED, PIX_BLACK,   1'b1},
        // 3x3 frame: white field, black corner turns the center into contour
        '{ROW_WRITE, REG_WIDTH,  32'd3,         MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, REG_HEIGHT, 32'h0001_0003, MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_READ,  REG_HEIGHT, 32'd3,         MODE_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, PIX_BLACK, CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, PIX_WHITE, CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_DRAIN, 8'h00,     CHK_QUIET, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, PIX_WHITE, CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, PIX_WHITE, CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, PIX_WHITE, CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, PIX_WHITE, CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, PIX_WHITE, CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, PIX_WHITE, CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, PIX_WHITE, CHK_TYPED, PIX_CONTOUR, 1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_DRAIN, 8'h00,     CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_PIXEL, 8'h81,     CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_DRAIN, 8'h7E,     CHK_MODEL, 8'h00,   1'b0},
        '{ROW_BEAT,  REG_WIDTH,  32'd0, MODE_DRAIN, 8'hFF,     CHK_TYPED, PIX_WHITE, 1'b1}
    };

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_mode  = MODE_PIXEL;
    logic [PIXEL_W-1:0]  s_pixel = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [PIXEL_W-1:0]  m_out_pixel;
    logic                m_frame_end;

    // Predicted block state
    logic [PIXEL_W-1:0]  line_above   [LINE_DEPTH] = '{default: '0};
    logic [PIXEL_W-1:0]  line_current [LINE_DEPTH] = '{default: '0};
    logic [PIXEL_W-1:0]  win [9] = '{default: '0};
    int unsigned         in_col       = 0;
    int unsigned         in_row       = 0;
    int unsigned         out_count    = 0;
    int unsigned         frame_width  = RESET_WIDTH;
    int unsigned         frame_height = RESET_HEIGHT;

    out_beat_t           pending_pixels [$];
    int unsigned         fault_count  = 0;
    int unsigned         taken_beats  = 0;
    int                  burst_left   = 0;
    int                  quiet_cycles = 0;
    bit                  squeeze_req  = 1'b0;

    binary_contour_window_3x3_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel),
        .m_frame_end (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void flag_fault(string what, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
        fault_count++;
        if (fault_count <= REPORT_CAP) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // Track a register write the way the block accepts it
    function automatic void apply_register(reg_index_t idx, logic [DATA_W-1:0] value);
        int unsigned field;
        if (idx == REG_WIDTH) begin
            field = value[WIDTH_W-1:0];
            if (field >= 1 && field <= LINE_DEPTH) frame_width = field;
        end else begin
            field = value[HEIGHT_W-1:0];
            if (field >= 1) frame_height = field;
        end
    endfunction

    // Advance the predicted pipeline by one accepted beat; returns 1 when it yields a result
    function automatic bit predict_boundary(input logic md, input logic [PIXEL_W-1:0] px,
                                            output bit taken, output out_beat_t beat);
        bit                 flushing;
        bit                 interior;
        int unsigned        pos;
        int unsigned        crow;
        int unsigned        ccol;
        logic [PIXEL_W-1:0] fresh;
        beat = '0;
        flushing = (in_row >= frame_height);
        taken = !(md == MODE_DRAIN && !flushing);
        // drop a drain that arrives while the frame is still coming in
        if (!taken) return 1'b0;
        fresh = flushing ? PIX_BLACK : px;
        pos = in_row * frame_width + in_col;

        // shift the window left and load the new column from the line stores
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = line_above[in_col];
        win[5] = line_current[in_col];
        win[8] = fresh;
        line_above[in_col]   = line_current[in_col];
        line_current[in_col] = fresh;

        if (in_col + 1 >= frame_width) begin
            in_col = 0;
            if (in_row < 32'h0000_FFFF) in_row++;
        end else begin
            in_col++;
        end
        if (pos < frame_width + 1) return 1'b0;

        // judge the center against its eight neighbors
        crow = out_count / frame_width;
        ccol = out_count % frame_width;
        interior = crow >= 1 && crow + 1 < frame_height && ccol >= 1 && ccol + 1 < frame_width;
        beat.pixel = win[4];
        if (interior && win[4] == PIX_WHITE) begin
            for (int k = 0; k < 9; k++) begin
                if (k != 4 && win[k] == PIX_BLACK) beat.pixel = PIX_CONTOUR;
            end
        end
        beat.frame_end = (out_count + 1 >= frame_width * frame_height);
        if (beat.frame_end) begin
            out_count = 0;
            in_col = 0;
            in_row = 0;
        end else begin
            out_count = (out_count + 1) & 32'h03FF_FFFF;
        end
        return 1'b1;
    endfunction

    // Mostly white with black specks, so contours show up often
    function automatic logic [PIXEL_W-1:0] random_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return PIX_WHITE;
        if (pick < 8) return PIX_BLACK;
        return PIXEL_W'($urandom_range(0, 255));
    endfunction

    // Offer one input beat, in bursts with random gaps, and record what it should yield
    task automatic send_beat(input logic md, input logic [PIXEL_W-1:0] px,
                             input check_e chk, input out_beat_t typed);
        bit        taken;
        bit        has_result;
        out_beat_t predicted;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 250)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_mode  <= md;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        has_result = predict_boundary(md, px, taken, predicted);
        if (taken) taken_beats++;
        case (chk)
            CHK_MODEL: begin
                if (has_result) pending_pixels.push_back(predicted);
            end
            CHK_TYPED: begin
                pending_pixels.push_back(typed);
            end
            default: ;
        endcase
    endtask

    // Drop valid, wait for every pending result, then let the pipeline go quiet
    task automatic settle_input();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register access: setup cycle, access cycle, then psel drops back to idle
    task automatic reg_access(input logic wr, input reg_index_t idx,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr) apply_register(idx, wdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        logic [DATA_W-1:0] rd;
        settle_input();
        reg_access(1'b1, REG_WIDTH, w, rd);
        reg_access(1'b1, REG_HEIGHT, h, rd);
    endtask

    // One frame of pixels plus its drain tail; now and then cut short or sprinkled with noise
    task automatic run_frame();
        int unsigned npix;
        int unsigned ndrain;
        npix = frame_width * frame_height;
        ndrain = frame_width + 1;
        if ($urandom_range(0, 7) == 0) ndrain = $urandom_range(0, ndrain);
        for (int unsigned p = 0; p < npix; p++) begin
            if ($urandom_range(0, 24) == 0) begin
                send_beat(MODE_DRAIN, PIXEL_W'($urandom), CHK_MODEL, '0);
            end
            send_beat(MODE_PIXEL, random_pixel(), CHK_MODEL, '0);
        end
        for (int unsigned d = 0; d < ndrain; d++) begin
            send_beat(($urandom_range(0, 4) == 0) ? MODE_PIXEL : MODE_DRAIN,
                      PIXEL_W'($urandom), CHK_MODEL, '0);
        end
    endtask

    // Feed whatever the current frame still needs until the counters are back at the start
    task automatic close_frame();
        while (in_row != 0 || in_col != 0 || out_count != 0) begin
            send_beat((in_row >= frame_height) ? MODE_DRAIN : MODE_PIXEL, random_pixel(),
                      CHK_MODEL, '0);
        end
    endtask

    // Main sequence: reset, directed table, fixed and random geometries, wind-down
    initial begin : stimulus
        step_row_t         row;
        logic [DATA_W-1:0] rd;
        int unsigned       first;
        int unsigned       w;
        int unsigned       h;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            row = SCRIPT[i];
            case (row.kind)
                ROW_WRITE: begin
                    settle_input();
                    reg_access(1'b1, row.idx, row.data, rd);
                end
                ROW_READ: begin
                    settle_input();
                    reg_access(1'b0, row.idx, '0, rd);
                    if (rd !== row.data) flag_fault("register read", row.data, rd);
                end
                default: begin
                    send_beat(row.mode, row.pix, row.chk, {row.exp_pix, row.exp_end});
                end
            endcase
        end

        // widest frame, with the result side held off for a while mid-frame
        set_geometry(LINE_DEPTH, 3);
        squeeze_req = 1'b1;
        run_frame();
        close_frame();

        // degenerate shapes: all border
        set_geometry(2, 1);
        repeat (3) run_frame();
        close_frame();
        set_geometry(1, 9);
        repeat (2) run_frame();
        close_frame();

        first = taken_beats;
        while (taken_beats - first < RANDOM_BEATS) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
            h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            set_geometry(w, h);
            repeat ($urandom_range(1, 3)) run_frame();
            close_frame();
        end

        settle_input();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("binary_contour_window_3x3_unit: match");
        end else begin
            $display("binary_contour_window_3x3_unit: mismatch");
        end
        $finish;
    end

    // Result side: stretches of differing stall density, plus one long hold on request
    initial begin : result_sink
        int unsigned stretch;
        sink_style_e style;
        @(posedge aclk);
        forever begin
            stretch = $urandom_range(4, 60);
            style = sink_style_e'($urandom_range(0, 3));
            repeat (stretch) begin
                case (style)
                    SINK_OPEN:  m_ready <= 1'b1;
                    SINK_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                    SINK_HALF:  m_ready <= ($urandom_range(0, 1) != 0);
                    default:    m_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge aclk);
            end
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
        end
    end

    // Compare each result beat with the oldest pending prediction
    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                flag_fault("result beat with nothing pending, out_pixel", '0, m_out_pixel);
            end else begin
                want = pending_pixels.pop_front();
                if (m_out_pixel !== want.pixel) begin
                    flag_fault("out_pixel", want.pixel, m_out_pixel);
                end
                if (m_frame_end !== want.frame_end) begin
                    flag_fault("frame_end", want.frame_end, m_frame_end);
                end
            end
        end
    end

    // Abort when no beat moves on any port for too long
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("binary_contour_window_3x3_unit: mismatch");
            $finish;
        end
    end

endmodule
